// ===== design/sstake_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sorted store with floor take.
// Holds status codes, request modes and the control struct sent to the cells.
package sstake_pkg;

    localparam int OCC_BITS = 7;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_TAKEN    = 2'd1,
        ST_NONE     = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_TAKE   = 1'b1;

    typedef struct packed {
        logic insert_en;
        logic take_en;
    } cell_ctl_t;

endpackage

// ===== design/sstake_in_if.sv =====
`timescale 1ns / 1ps
// Request channel of the sorted store: valid, ready and the request payload.
// Depends on no other file.
interface sstake_in_if #(
    parameter int VALUE_BITS = 20
);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

// ===== design/sstake_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the sorted store: valid, ready and the result payload.
// Depends on sstake_pkg for the occupancy width.
interface sstake_out_if #(
    parameter int VALUE_BITS = 20
);
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [VALUE_BITS-1:0]            taken_value;
    logic [sstake_pkg::OCC_BITS-1:0]  occupancy;

    modport source (output valid, output status, output taken_value, output occupancy,
                    input ready);
    modport sink (input valid, input status, input taken_value, input occupancy,
                  output ready);
endinterface

// ===== design/sstake_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one value and moves it to or from a neighbor.
// Depends on sstake_pkg for the cell control struct.
module sstake_cell #(
    parameter int VALUE_BITS = 20
) (
    input  logic                   clk,
    input  sstake_pkg::cell_ctl_t  ctl,
    input  logic [VALUE_BITS-1:0]  key,
    input  logic                   valid,
    input  logic                   le_left,
    input  logic                   le_right,
    input  logic [VALUE_BITS-1:0]  left_value,
    input  logic [VALUE_BITS-1:0]  right_value,
    output logic                   le,
    output logic [VALUE_BITS-1:0]  value
);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;

    assign le    = valid && (value_reg <= key);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.insert_en && !le)
        begin
            value_next = le_left ? key : left_value;
        end
        else if (ctl.take_en && !le_right)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== design/sstake_chain.sv =====
`timescale 1ns / 1ps
// Row of sorted cells with neighbor wiring and the one-hot pick of the taken value.
// Depends on sstake_pkg and sstake_cell.
module sstake_chain #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 20,
    parameter int CNT_BITS   = $clog2(CAPACITY + 1)
) (
    input  logic                   clk,
    input  sstake_pkg::cell_ctl_t  ctl,
    input  logic [VALUE_BITS-1:0]  key,
    input  logic [CNT_BITS-1:0]    count,
    output logic                   fit,
    output logic [VALUE_BITS-1:0]  taken_value
);

    logic [CAPACITY-1:0]   le;
    logic [CAPACITY-1:0]   pick;
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                  valid;
            logic                  le_left;
            logic                  le_right;
            logic [VALUE_BITS-1:0] left_value;
            logic [VALUE_BITS-1:0] right_value;

            assign valid = CNT_BITS'(i) < count;

            if (i == 0)
            begin : g_first
                assign le_left    = 1'b1;
                assign left_value = key;
            end
            else
            begin : g_mid_left
                assign le_left    = le[i-1];
                assign left_value = cell_value[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign le_right    = 1'b0;
                assign right_value = cell_value[i];
            end
            else
            begin : g_mid_right
                assign le_right    = le[i+1];
                assign right_value = cell_value[i+1];
            end

            assign pick[i] = le[i] && !le_right;

            sstake_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .key         (key),
                .valid       (valid),
                .le_left     (le_left),
                .le_right    (le_right),
                .left_value  (left_value),
                .right_value (right_value),
                .le          (le[i]),
                .value       (cell_value[i])
            );
        end
    endgenerate

    assign fit = le[0];

    always_comb
    begin
        taken_value = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            taken_value = taken_value | (cell_value[k] & {VALUE_BITS{pick[k]}});
        end
    end

endmodule

// ===== design/sorted_store_floor_take.sv =====
`timescale 1ns / 1ps
// Sorted store with floor take: a chain of cells kept in ascending order.
// The result is registered and is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while ready is high; cells compare and shift at accept.
// Ready drops only while a result waits and the result side is stalled.
// Reset clears the count and the result valid; cell contents stay unwritten until used.
module sorted_store_floor_take #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 20
) (
    input  logic clk,
    input  logic rst_n,
    sstake_in_if.sink    in_req,
    sstake_out_if.source out_rsp
);

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    logic                  accept;
    logic                  full;
    logic                  fit;
    logic [VALUE_BITS-1:0] chain_taken;
    sstake_pkg::cell_ctl_t ctl;

    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    sstake_pkg::status_t   status_reg;
    sstake_pkg::status_t   status_next;
    logic [VALUE_BITS-1:0] taken_reg;
    logic [VALUE_BITS-1:0] taken_next;

    assign in_req.ready = !out_valid_reg || out_rsp.ready;
    assign accept       = in_req.valid && in_req.ready;
    assign full         = count_reg == CNT_BITS'(CAPACITY);

    assign ctl.insert_en = accept && (in_req.mode == sstake_pkg::MODE_INSERT) && !full;
    assign ctl.take_en   = accept && (in_req.mode == sstake_pkg::MODE_TAKE) && fit;

    sstake_chain #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .CNT_BITS   (CNT_BITS)
    ) u_chain (
        .clk         (clk),
        .ctl         (ctl),
        .key         (in_req.value),
        .count       (count_reg),
        .fit         (fit),
        .taken_value (chain_taken)
    );

    always_comb
    begin
        count_next = count_reg;
        taken_next = '0;
        if (in_req.mode == sstake_pkg::MODE_INSERT)
        begin
            status_next = full ? sstake_pkg::ST_FULL : sstake_pkg::ST_INSERTED;
        end
        else
        begin
            status_next = fit ? sstake_pkg::ST_TAKEN : sstake_pkg::ST_NONE;
        end
        if (ctl.insert_en)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (ctl.take_en)
        begin
            count_next = count_reg - CNT_BITS'(1);
            taken_next = chain_taken;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            taken_reg  <= taken_next;
        end
    end

    assign out_rsp.valid       = out_valid_reg;
    assign out_rsp.status      = status_reg;
    assign out_rsp.taken_value = taken_reg;
    assign out_rsp.occupancy   = sstake_pkg::OCC_BITS'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(CAPACITY))
        else $error("stored count exceeds capacity");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_req.mode == sstake_pkg::MODE_INSERT) && full)
        |=> (out_rsp.status == sstake_pkg::ST_FULL) && $stable(count_reg))
        else $error("insert into full store was not dropped");

    a_take_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_req.mode == sstake_pkg::MODE_TAKE))
        |=> (out_rsp.taken_value <= $past(in_req.value)))
        else $error("taken value above the limit");

    a_zero_unless_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_rsp.status != sstake_pkg::ST_TAKEN))
        |-> (out_rsp.taken_value == '0))
        else $error("taken value not zero without a take");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_rsp.occupancy == sstake_pkg::OCC_BITS'(count_reg)))
        else $error("occupancy does not match stored count");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_store_floor_take: inserts and floor takes are predicted
// against a local sorted copy of the store under random bursts, stalls and a long hold-off.
// Depends on sstake_pkg, sstake_in_if, sstake_out_if and the block itself.
module tb_top;

    localparam int CAPACITY      = 64;
    localparam int VB            = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int TAIL_CYCLES   = 8;
    localparam logic [VB-1:0] VALUE_MAX = {VB{1'b1}};

    typedef struct {
        logic          mode;
        logic [VB-1:0] value;
    } store_req_t;

    typedef struct {
        sstake_pkg::status_t               status;
        logic [VB-1:0]                     taken_value;
        logic [sstake_pkg::OCC_BITS-1:0]   occupancy;
    } store_rsp_t;

    logic clk;
    logic rst_n;

    sstake_in_if  #(.VALUE_BITS(VB)) req_if ();
    sstake_out_if #(.VALUE_BITS(VB)) rsp_if ();

    sorted_store_floor_take #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VB)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_req  (req_if),
        .out_rsp (rsp_if)
    );

    store_req_t pending_requests[$];
    store_rsp_t expected_responses[$];

    logic [VB-1:0] model_values [CAPACITY];
    int            model_count;

    int errors;
    int results_seen;
    int inserted_seen;
    int taken_seen;
    int none_seen;
    int full_seen;
    int peak_occupancy;
    int hold_token;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic store_rsp_t predict_store_response(logic mode, logic [VB-1:0] value);
        store_rsp_t rsp;
        int         pos;
        rsp.status      = sstake_pkg::ST_INSERTED;
        rsp.taken_value = '0;
        pos = 0;
        while (pos < model_count && model_values[pos] <= value)
            pos++;
        if (mode == sstake_pkg::MODE_INSERT)
        begin
            if (model_count >= CAPACITY)
                rsp.status = sstake_pkg::ST_FULL;
            else
            begin
                for (int i = model_count; i > pos; i--)
                    model_values[i] = model_values[i-1];
                model_values[pos] = value;
                model_count++;
            end
        end
        else if (pos == 0)
            rsp.status = sstake_pkg::ST_NONE;
        else
        begin
            rsp.status      = sstake_pkg::ST_TAKEN;
            rsp.taken_value = model_values[pos-1];
            for (int i = pos - 1; i + 1 < model_count; i++)
                model_values[i] = model_values[i+1];
            model_count--;
        end
        rsp.occupancy = sstake_pkg::OCC_BITS'(model_count);
        return rsp;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        errors++;
    endtask

    task automatic add_request(logic mode, logic [VB-1:0] value);
        store_req_t req;
        req.mode  = mode;
        req.value = value;
        pending_requests.insert(pending_requests.size(), req);
    endtask

    function automatic logic [VB-1:0] pick_value();
        logic [VB-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = VB'($urandom);
            4, 5:       v = VB'($urandom_range(0, 31));
            6:          v = $urandom_range(0, 1) ? VALUE_MAX : '0;
            7:          v = VALUE_MAX - VB'($urandom_range(0, 15));
            default:    v = VB'($urandom_range(1000, 1063));
        endcase
        return v;
    endfunction

    task automatic queue_mixed(int n, int insert_pct);
        for (int i = 0; i < n; i++)
            add_request(($urandom_range(0, 99) < insert_pct) ? sstake_pkg::MODE_INSERT
                                                              : sstake_pkg::MODE_TAKE,
                        pick_value());
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_requests.size() != 0 || req_if.valid || expected_responses.size() != 0)
            @(negedge clk);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    int         burst_left;
    int         gap_left;
    store_req_t next_req;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.mode  <= sstake_pkg::MODE_INSERT;
            req_if.value <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                expected_responses.insert(expected_responses.size(),
                                          predict_store_response(req_if.mode, req_if.value));
            if (!req_if.valid || req_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_req = pending_requests.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.mode  <= next_req.mode;
                    req_if.value <= next_req.value;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: a rotating stall mask, plus a long hold-off on request.
    int          hold_served;
    int          hold_left;
    int          pattern_left;
    int          pattern_pos;
    logic [15:0] stall_mask;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            hold_served  = 0;
            hold_left    = 0;
            pattern_left = 0;
            pattern_pos  = 0;
            stall_mask   = 16'hFFFF;
        end
        else
        begin
            if (hold_served != hold_token)
            begin
                hold_served = hold_token;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       stall_mask = 16'hFFFF;
                        1:       stall_mask = 16'($urandom);
                        2:       stall_mask = 16'hAAAA;
                        default: stall_mask = 16'($urandom) | 16'($urandom);
                    endcase
                    if (stall_mask == 16'h0000)
                        stall_mask = 16'h0001;
                    pattern_left = $urandom_range(16, 64);
                end
                pattern_left--;
                rsp_if.ready <= stall_mask[pattern_pos];
                pattern_pos = (pattern_pos + 1) % 16;
            end
        end
    end

    // Result monitor.
    store_rsp_t want;

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            results_seen++;
            case (sstake_pkg::status_t'(rsp_if.status))
                sstake_pkg::ST_INSERTED: inserted_seen++;
                sstake_pkg::ST_TAKEN:    taken_seen++;
                sstake_pkg::ST_NONE:     none_seen++;
                default:                 full_seen++;
            endcase
            if (int'(rsp_if.occupancy) > peak_occupancy)
                peak_occupancy = int'(rsp_if.occupancy);
            if (expected_responses.size() == 0)
                report_mismatch("result arrived with no request outstanding");
            else
            begin
                want = expected_responses.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp_if.status, want.status));
                if (rsp_if.taken_value !== want.taken_value)
                    report_mismatch($sformatf("taken_value 0x%05h, expected 0x%05h",
                                              rsp_if.taken_value, want.taken_value));
                if (rsp_if.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, expected %0d",
                                              rsp_if.occupancy, want.occupancy));
            end
        end
    end

    int idle_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_responses.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.mode   = sstake_pkg::MODE_INSERT;
        req_if.value  = '0;
        rsp_if.ready  = 1'b0;
        model_count   = 0;
        errors        = 0;
        results_seen  = 0;
        inserted_seen = 0;
        taken_seen    = 0;
        none_seen     = 0;
        full_seen     = 0;
        peak_occupancy = 0;
        hold_token    = 0;
        idle_cycles   = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Takes on an empty store, extremes, duplicates and takes that find no fit.
        add_request(sstake_pkg::MODE_TAKE,   VALUE_MAX);
        add_request(sstake_pkg::MODE_TAKE,   '0);
        add_request(sstake_pkg::MODE_INSERT, '0);
        add_request(sstake_pkg::MODE_INSERT, VALUE_MAX);
        add_request(sstake_pkg::MODE_INSERT, VB'(7));
        add_request(sstake_pkg::MODE_INSERT, VB'(7));
        add_request(sstake_pkg::MODE_INSERT, VB'(7));
        add_request(sstake_pkg::MODE_TAKE,   VB'(6));
        add_request(sstake_pkg::MODE_TAKE,   VB'(6));
        add_request(sstake_pkg::MODE_TAKE,   VB'(7));
        add_request(sstake_pkg::MODE_TAKE,   VALUE_MAX - 1);
        add_request(sstake_pkg::MODE_TAKE,   VALUE_MAX);
        add_request(sstake_pkg::MODE_TAKE,   VALUE_MAX);
        add_request(sstake_pkg::MODE_TAKE,   VALUE_MAX);
        add_request(sstake_pkg::MODE_INSERT, VB'(20'hAAAAA));
        add_request(sstake_pkg::MODE_INSERT, VB'(20'h55555));
        add_request(sstake_pkg::MODE_TAKE,   VB'(20'h55554));
        add_request(sstake_pkg::MODE_TAKE,   VB'(20'hAAAAA));
        add_request(sstake_pkg::MODE_TAKE,   VB'(20'hAAAAA));
        add_request(sstake_pkg::MODE_TAKE,   VALUE_MAX);
        wait_idle();

        // Fill past capacity so that inserts get dropped.
        for (int i = 0; i < 75; i++)
            add_request(sstake_pkg::MODE_INSERT, pick_value());
        wait_idle();

        // Long result-side hold-off while requests keep coming.
        hold_token++;
        queue_mixed(40, 50);
        queue_mixed(250, 50);
        wait_idle();

        // Drain the store and keep taking once it is empty.
        for (int i = 0; i < 80; i++)
            add_request(sstake_pkg::MODE_TAKE,
                        ($urandom_range(0, 3) == 0) ? pick_value() : VALUE_MAX);
        wait_idle();

        queue_mixed(200, 65);
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d requests: %0d inserted, %0d taken, %0d with no fit, %0d dropped.",
                 results_seen, inserted_seen, taken_seen, none_seen, full_seen);
        $display("Peak occupancy %0d of %0d, including a %0d-cycle result hold-off.",
                 peak_occupancy, CAPACITY, HOLD_CYCLES);
        if (errors == 0 && expected_responses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
